>>> src/bcu_pkg.sv
// shared types, microcode program and constant tables for the binomial coefficient unit
// no dependencies; used by bcu_seq and binomial_coefficient_unit
`timescale 1ns / 1ps
`default_nettype none

package bcu_pkg;

  localparam int unsigned CoefW  = 60;
  localparam int unsigned HalfW  = 30;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned ExpW   = 6;
  localparam int unsigned TzW    = 3;
  localparam int unsigned UpcW   = 3;
  localparam int unsigned InvN   = 16;
  localparam int unsigned InvIdxW = 4;

  typedef logic [UpcW-1:0] upc_t;

  // datapath operation selected by the control word
  typedef enum logic [2:0] {
    OP_NOP  = 3'd0,
    OP_LOAD = 3'd1,
    OP_WGEN = 3'd2,
    OP_MUL0 = 3'd3,
    OP_MUL1 = 3'd4,
    OP_MUL2 = 3'd5,
    OP_FIN  = 3'd6
  } op_e;

  // sequencing condition of the control word
  typedef enum logic [2:0] {
    C_NEXT      = 3'd0,
    C_WAIT_IN   = 3'd1,
    C_SKIP_NONE = 3'd2,
    C_LOOP      = 3'd3,
    C_WAIT_OUT  = 3'd4,
    C_HOME      = 3'd5
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  tgt;
  } uword_t;

  typedef struct packed {
    logic in_xfer;
    logic no_steps;
    logic more;
    logic out_free;
  } seq_stat_t;

  typedef struct packed {
    op_e  op;
    logic in_ready;
  } seq_ctrl_t;

  localparam upc_t UA_IDLE  = 3'd0;
  localparam upc_t UA_CHECK = 3'd1;
  localparam upc_t UA_WGEN  = 3'd2;
  localparam upc_t UA_MUL0  = 3'd3;
  localparam upc_t UA_MUL1  = 3'd4;
  localparam upc_t UA_MUL2  = 3'd5;
  localparam upc_t UA_FIN   = 3'd6;
  localparam upc_t UA_SPARE = 3'd7;

  // control store
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    unique case (a)
      UA_IDLE:  w = '{op: OP_LOAD, cond: C_WAIT_IN,   tgt: UA_IDLE};
      UA_CHECK: w = '{op: OP_NOP,  cond: C_SKIP_NONE, tgt: UA_FIN};
      UA_WGEN:  w = '{op: OP_WGEN, cond: C_NEXT,      tgt: UA_IDLE};
      UA_MUL0:  w = '{op: OP_MUL0, cond: C_NEXT,      tgt: UA_IDLE};
      UA_MUL1:  w = '{op: OP_MUL1, cond: C_NEXT,      tgt: UA_IDLE};
      UA_MUL2:  w = '{op: OP_MUL2, cond: C_LOOP,      tgt: UA_WGEN};
      UA_FIN:   w = '{op: OP_FIN,  cond: C_WAIT_OUT,  tgt: UA_IDLE};
      default:  w = '{op: OP_NOP,  cond: C_HOME,      tgt: UA_IDLE};
    endcase
    return w;
  endfunction

  // trailing zero count of a small value
  function automatic logic [TzW-1:0] tz6(logic [IdxW-1:0] v);
    logic [TzW-1:0] t;
    t = '0;
    for (int k = IdxW - 1; k >= 0; k--) begin
      if (v[k]) begin
        t = TzW'(k);
      end
    end
    return t;
  endfunction

  // inverses of the odd numbers 1..31 modulo 2^60
  typedef logic [CoefW-1:0] inv_tab_t [InvN];

  function automatic inv_tab_t build_inv();
    inv_tab_t         tab;
    logic [CoefW-1:0] o;
    logic [CoefW-1:0] x;
    logic [CoefW-1:0] t;
    for (int k = 0; k < InvN; k++) begin
      o = CoefW'(2 * k + 1);
      x = o;
      for (int s = 0; s < 5; s++) begin
        t = CoefW'(o * x);
        x = CoefW'(x * (CoefW'(2) - t));
      end
      tab[k] = x;
    end
    return tab;
  endfunction

  localparam inv_tab_t InvTab = build_inv();

endpackage

`default_nettype wire

>>> src/binomial_coefficient_unit.sv
// binomial_coefficient_unit: exact n choose r for rows up to 63 on a microcoded datapath
// depends on bcu_pkg and bcu_seq
//
// One query at a time. A query runs the program loop once for each step index 1..k, where
// k = min(r, n-r) (at most 31); each loop step (WGEN, MUL0, MUL1, MUL2) uses one shared
// 30x30 multiplier three times. The running value is kept as an odd part modulo 2^60 and a
// power of two, so the exact division by each step index is a multiply by a tabulated
// inverse. A finished result sits in an output register; a new query is taken as soon as
// the program is back at its first step. r > n gives 0 with index_beyond_row set.
`timescale 1ns / 1ps
`default_nettype none

module binomial_coefficient_unit #(
  parameter int unsigned MAX_ROW = 63
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [5:0]  row_number_i,
  input  wire logic [5:0]  element_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [59:0]      coefficient_o,
  output logic             index_beyond_row_o
);

  localparam int unsigned CoefW = bcu_pkg::CoefW;
  localparam int unsigned HalfW = bcu_pkg::HalfW;
  localparam int unsigned IdxW  = bcu_pkg::IdxW;
  localparam int unsigned ExpW  = bcu_pkg::ExpW;
  localparam int unsigned RowW  = 7;

  bcu_pkg::seq_stat_t stat;
  bcu_pkg::seq_ctrl_t ctrl;

  logic [IdxW-1:0]  steps_q, steps_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  base_q, base_d;
  logic [ExpW-1:0]  exp_q, exp_d;
  logic [CoefW-1:0] odd_q, odd_d;
  logic [CoefW-1:0] w_q, w_d;
  logic [CoefW-1:0] acc_q, acc_d;
  logic             beyond_q, beyond_d;
  logic [CoefW-1:0] coef_q;
  logic             flag_q;
  logic             out_valid_q;

  logic             in_xfer, out_free, fin_wr;
  logic             beyond, over;
  logic [IdxW-1:0]  rem, rmin;
  logic [IdxW-1:0]  idx, mval, oddm, oddi;
  logic [bcu_pkg::TzW-1:0] tzm, tzi;
  logic [RowW-1:0]  exp_sum;
  logic [HalfW-1:0] mul_a, mul_b;
  logic [2*HalfW-1:0] mul_p;
  logic [CoefW-1:0] upper_add;

  assign in_ready_o = ctrl.in_ready;
  assign in_xfer    = in_valid_i & ctrl.in_ready;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign fin_wr     = (ctrl.op == bcu_pkg::OP_FIN) & out_free;

  assign stat.in_xfer  = in_xfer;
  assign stat.no_steps = (cnt_q >= steps_q);
  assign stat.more     = (cnt_q < steps_q);
  assign stat.out_free = out_free;

  bcu_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // query setup
  assign beyond = (element_index_i > row_number_i);
  assign over   = ({1'b0, row_number_i} > RowW'(MAX_ROW));
  assign rem    = row_number_i - element_index_i;
  assign rmin   = (rem < element_index_i) ? rem : element_index_i;

  // step operands
  assign idx     = cnt_q + 1'b1;
  assign mval    = base_q + idx;
  assign tzm     = bcu_pkg::tz6(mval);
  assign tzi     = bcu_pkg::tz6(idx);
  assign oddm    = mval >> tzm;
  assign oddi    = idx >> tzi;
  assign exp_sum = {1'b0, exp_q} + RowW'(tzm) - RowW'(tzi);

  // shared multiplier
  always_comb begin
    case (ctrl.op)
      bcu_pkg::OP_MUL1: begin
        mul_a = odd_q[HalfW-1:0];
        mul_b = w_q[CoefW-1:HalfW];
      end
      bcu_pkg::OP_MUL2: begin
        mul_a = odd_q[CoefW-1:HalfW];
        mul_b = w_q[HalfW-1:0];
      end
      default: begin
        mul_a = odd_q[HalfW-1:0];
        mul_b = w_q[HalfW-1:0];
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign upper_add = {mul_p[HalfW-1:0], {HalfW{1'b0}}};

  always_comb begin
    steps_d  = steps_q;
    cnt_d    = cnt_q;
    base_d   = base_q;
    exp_d    = exp_q;
    odd_d    = odd_q;
    w_d      = w_q;
    acc_d    = acc_q;
    beyond_d = beyond_q;
    unique case (ctrl.op)
      bcu_pkg::OP_LOAD: begin
        if (in_xfer) begin
          steps_d  = (beyond | over) ? '0 : rmin;
          base_d   = row_number_i - rmin;
          odd_d    = (beyond | over) ? '0 : CoefW'(1);
          exp_d    = '0;
          cnt_d    = '0;
          beyond_d = beyond;
        end
      end
      bcu_pkg::OP_WGEN: begin
        w_d   = CoefW'(oddm * bcu_pkg::InvTab[oddi[bcu_pkg::InvIdxW:1]]);
        exp_d = exp_sum[ExpW-1:0];
        cnt_d = idx;
      end
      bcu_pkg::OP_MUL0: acc_d = mul_p;
      bcu_pkg::OP_MUL1: acc_d = acc_q + upper_add;
      bcu_pkg::OP_MUL2: odd_d = acc_q + upper_add;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q  <= '0;
      cnt_q    <= '0;
      base_q   <= '0;
      exp_q    <= '0;
      odd_q    <= '0;
      beyond_q <= 1'b0;
    end else begin
      steps_q  <= steps_d;
      cnt_q    <= cnt_d;
      base_q   <= base_d;
      exp_q    <= exp_d;
      odd_q    <= odd_d;
      beyond_q <= beyond_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    acc_q <= acc_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_wr) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_wr) begin
      coef_q <= odd_q << exp_q;
      flag_q <= beyond_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign coefficient_o      = coef_q;
  assign index_beyond_row_o = flag_q;

endmodule

`default_nettype wire

>>> src/bcu_seq.sv
// microcode sequencer: program counter, control store readout and jump logic
// depends on bcu_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcu_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bcu_pkg::seq_stat_t stat_i,
  output bcu_pkg::seq_ctrl_t     ctrl_o
);

  bcu_pkg::upc_t   pc_q, pc_d;
  bcu_pkg::uword_t uw;

  assign uw = bcu_pkg::ucode(pc_q);

  always_comb begin
    unique case (uw.cond)
      bcu_pkg::C_NEXT:      pc_d = pc_q + 1'b1;
      bcu_pkg::C_WAIT_IN:   pc_d = stat_i.in_xfer ? pc_q + 1'b1 : pc_q;
      bcu_pkg::C_SKIP_NONE: pc_d = stat_i.no_steps ? uw.tgt : pc_q + 1'b1;
      bcu_pkg::C_LOOP:      pc_d = stat_i.more ? uw.tgt : pc_q + 1'b1;
      bcu_pkg::C_WAIT_OUT:  pc_d = stat_i.out_free ? uw.tgt : pc_q;
      bcu_pkg::C_HOME:      pc_d = uw.tgt;
      default:              pc_d = bcu_pkg::UA_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= bcu_pkg::UA_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op       = uw.op;
  assign ctrl_o.in_ready = (uw.cond == bcu_pkg::C_WAIT_IN);

endmodule

`default_nettype wire
